[sv/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// shared types and constants of the bitmap slot allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

    // build defaults
    localparam int SLOTS_DEF       = 256;
    localparam int RECORD_BITS_DEF = 64;

    // field widths
    localparam int CMD_W     = 3;
    localparam int SLOT_W    = 11;
    localparam int DATA_W    = 64;
    localparam int STATUS_W  = 3;
    localparam int RSLOT_W   = 8;
    localparam int PAGE_W    = 16;
    localparam int USED_W    = 9;
    localparam int SIU_W     = 9;

    // stream packing
    localparam int IN_TDATA_W   = 80;
    localparam int OUT_FIELDS_W = RSLOT_W + PAGE_W + DATA_W + USED_W + 2;
    localparam int OUT_TDATA_W  = 104;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOTS_IN_USE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_NUMBER  = 8'd1;
    localparam logic [SIU_W-1:0]       SIU_RESET        = 9'd256;

    // occupancy bitmap word
    localparam int MAP_WORD_BITS = 32;
    localparam int BIT_IDX_W     = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_DELETE   = 3'd1,
        CMD_GET      = 3'd2,
        CMD_GET_NEXT = 3'd3,
        CMD_UPDATE   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_RANGE   = 3'd1,
        STS_EMPTY   = 3'd2,
        STS_NO_FREE = 3'd3,
        STS_END     = 3'd4
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic accept;   // latch request
        logic clear;    // clear one bitmap word
        logic decode;   // range checks, first bitmap read
        logic eval;     // evaluate bitmap word
        logic capture;  // take record read data
        logic load;     // load output register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic dec_done;
        logic ev_more;
        logic ev_rec;
        logic out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

[sv/bsa_ctrl.sv]
// ----------------------------------------------------------------------------
// bsa_ctrl
// sequencer of the bitmap slot allocator: clear pass, then one request at a time
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl
    import bsa_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire dp_sts_t    sts,
    output ctrl_cmd_t       cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_DECODE = 6'b000100,
        ST_EVAL   = 6'b001000,
        ST_RDATA  = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = sts.dec_done ? ST_DONE : ST_EVAL;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (sts.ev_more) begin
                    state_next = ST_EVAL;
                end else if (sts.ev_rec) begin
                    state_next = ST_RDATA;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RDATA: begin
                cmd.capture = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/bsa_datapath.sv]
// ----------------------------------------------------------------------------
// bsa_datapath
// bitmap word memory, record memory, used count, config and output register
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_datapath
    import bsa_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int RECORD_BITS = RECORD_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ctrl_cmd_t              cmd,
    output dp_sts_t                     sts,
    input  wire logic [CMD_W-1:0]       in_command,
    input  wire logic [SLOT_W-1:0]      in_slot,
    input  wire logic [DATA_W-1:0]      in_record_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [STATUS_W-1:0]         m_tuser
);

    localparam int NWORDS = (SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WI     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int SW     = WI + BIT_IDX_W;
    localparam int LIMW   = SW + 1;
    localparam int LCW    = (LIMW > SIU_W) ? LIMW : SIU_W;
    localparam int CMPW   = (LIMW > SLOT_W) ? LIMW : SLOT_W;
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int RI     = $clog2(SLOTS);

    function automatic logic [BIT_IDX_W-1:0] first_one(input logic [MAP_WORD_BITS-1:0] v);
        logic [BIT_IDX_W-1:0] r;
        r = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                r = BIT_IDX_W'(i);
            end
        end
        return r;
    endfunction

    // request and configuration
    cmd_t                   cmd_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [RECORD_BITS-1:0] data_reg;
    logic [SIU_W-1:0]       siu_reg;
    logic [PAGE_W-1:0]      page_reg;
    logic [CW-1:0]          count_reg;
    logic [WI-1:0]          clr_ptr_reg;
    logic [WI-1:0]          wptr_reg;

    // memories
    logic [MAP_WORD_BITS-1:0] map_mem [NWORDS];
    logic [MAP_WORD_BITS-1:0] map_q_reg;
    logic [RECORD_BITS-1:0]   rec_mem [SLOTS];
    logic [RECORD_BITS-1:0]   rec_q_reg;

    // result under construction and output register
    status_t                res_status_reg;
    logic [SW-1:0]          res_slot_reg;
    logic [RECORD_BITS-1:0] res_data_reg;
    logic                   out_valid_reg;
    status_t                out_status_reg;
    logic [RSLOT_W-1:0]     out_slot_reg;
    logic [PAGE_W-1:0]      out_page_reg;
    logic [RECORD_BITS-1:0] out_data_reg;
    logic [USED_W-1:0]      out_used_reg;
    logic                   out_full_reg;
    logic                   out_empty_reg;

    // limit and range checks
    logic [LCW-1:0]       lim_wide;
    logic [LIMW-1:0]      lim;
    logic [CMPW-1:0]      lim_c;
    logic                 slot_ok;
    logic [SLOT_W:0]      start;
    logic                 start_ok;
    logic [SW-1:0]        sidx;
    logic [SW-1:0]        stidx;
    logic [WI:0]          lim_word;
    logic [BIT_IDX_W-1:0] lim_bit;
    logic [WI:0]          w_ext;
    logic [WI:0]          w_nxt;
    logic [WI-1:0]        init_word;

    always_comb begin
        lim_wide = (LCW'(siu_reg) > LCW'(SLOTS)) ? LCW'(SLOTS) : LCW'(siu_reg);
        lim      = LIMW'(lim_wide);
        lim_c    = CMPW'(lim);
        slot_ok  = !slot_reg[SLOT_W-1] && (CMPW'(slot_reg[SLOT_W-2:0]) < lim_c);
        start    = {slot_reg[SLOT_W-1], slot_reg} + (SLOT_W + 1)'(1);
        start_ok = !start[SLOT_W] && (CMPW'(start[SLOT_W-1:0]) < lim_c);
        sidx     = SW'(slot_reg[SLOT_W-2:0]);
        stidx    = SW'(start[SLOT_W-1:0]);
        lim_word = lim[LIMW-1:BIT_IDX_W];
        lim_bit  = lim[BIT_IDX_W-1:0];
        w_ext    = {1'b0, wptr_reg};
        w_nxt    = w_ext + (WI + 1)'(1);
        case (cmd_reg)
            CMD_INSERT:   init_word = '0;
            CMD_GET_NEXT: init_word = stidx[SW-1:BIT_IDX_W];
            default:      init_word = sidx[SW-1:BIT_IDX_W];
        endcase
    end

    // early outcome after range checks
    status_t dec_status;
    logic    dec_done;

    always_comb begin
        dec_status = STS_OK;
        dec_done   = 1'b0;
        unique case (cmd_reg) inside
            CMD_INSERT: begin
                dec_done = 1'b0;
            end
            CMD_DELETE, CMD_GET, CMD_UPDATE: begin
                dec_status = STS_RANGE;
                dec_done   = !slot_ok;
            end
            CMD_GET_NEXT: begin
                dec_status = STS_END;
                dec_done   = !start_ok;
            end
            default: begin
                dec_done = 1'b1;
            end
        endcase
    end

    // bitmap word evaluation
    logic [MAP_WORD_BITS-1:0] lim_mask;
    logic [MAP_WORD_BITS-1:0] start_mask;
    logic [MAP_WORD_BITS-1:0] cand;
    logic                     found;
    logic [BIT_IDX_W-1:0]     fidx;
    logic [SW-1:0]            hit_slot;
    logic                     more_words;
    logic                     dir_bit;

    always_comb begin
        if (w_ext < lim_word) begin
            lim_mask = '1;
        end else if (w_ext == lim_word) begin
            lim_mask = (MAP_WORD_BITS'(1) << lim_bit) - MAP_WORD_BITS'(1);
        end else begin
            lim_mask = '0;
        end
        if (wptr_reg == stidx[SW-1:BIT_IDX_W]) begin
            start_mask = ~((MAP_WORD_BITS'(1) << stidx[BIT_IDX_W-1:0]) - MAP_WORD_BITS'(1));
        end else begin
            start_mask = '1;
        end
        if (cmd_reg == CMD_INSERT) begin
            cand = ~map_q_reg & lim_mask;
        end else begin
            cand = map_q_reg & lim_mask & start_mask;
        end
        found      = |cand;
        fidx       = first_one(cand);
        hit_slot   = {wptr_reg, fidx};
        more_words = (w_nxt < lim_word) || ((w_nxt == lim_word) && (lim_bit != '0));
        dir_bit    = map_q_reg[sidx[BIT_IDX_W-1:0]];
    end

    status_t                  ev_status;
    logic                     ev_set_slot;
    logic [SW-1:0]            ev_slot;
    logic                     ev_more;
    logic                     ev_rec_rd;
    logic                     ev_rec_wr;
    logic                     ev_map_wr;
    logic [MAP_WORD_BITS-1:0] ev_map_wdata;
    logic                     ev_inc;
    logic                     ev_dec;

    always_comb begin
        ev_status    = STS_OK;
        ev_set_slot  = 1'b0;
        ev_slot      = sidx;
        ev_more      = 1'b0;
        ev_rec_rd    = 1'b0;
        ev_rec_wr    = 1'b0;
        ev_map_wr    = 1'b0;
        ev_map_wdata = map_q_reg;
        ev_inc       = 1'b0;
        ev_dec       = 1'b0;
        unique case (cmd_reg) inside
            CMD_INSERT: begin
                ev_slot = hit_slot;
                if (found) begin
                    ev_set_slot  = 1'b1;
                    ev_rec_wr    = 1'b1;
                    ev_map_wr    = 1'b1;
                    ev_map_wdata = map_q_reg | (MAP_WORD_BITS'(1) << fidx);
                    ev_inc       = 1'b1;
                end else begin
                    ev_more   = more_words;
                    ev_status = STS_NO_FREE;
                end
            end
            CMD_GET_NEXT: begin
                ev_slot = hit_slot;
                if (found) begin
                    ev_set_slot = 1'b1;
                    ev_rec_rd   = 1'b1;
                end else begin
                    ev_more   = more_words;
                    ev_status = STS_END;
                end
            end
            CMD_DELETE, CMD_GET, CMD_UPDATE: begin
                if (!dir_bit) begin
                    ev_status = STS_EMPTY;
                end else begin
                    ev_set_slot = 1'b1;
                    if (cmd_reg == CMD_DELETE) begin
                        ev_map_wr    = 1'b1;
                        ev_map_wdata = map_q_reg &
                                       ~(MAP_WORD_BITS'(1) << sidx[BIT_IDX_W-1:0]);
                        ev_dec       = 1'b1;
                    end else if (cmd_reg == CMD_GET) begin
                        ev_rec_rd = 1'b1;
                    end else begin
                        ev_rec_wr = 1'b1;
                    end
                end
            end
            default: begin
                ev_status = STS_OK;
            end
        endcase
    end

    // memory ports
    logic                     map_we;
    logic [WI-1:0]            map_waddr;
    logic [MAP_WORD_BITS-1:0] map_wdata;
    logic                     map_re;
    logic [WI-1:0]            map_raddr;
    logic                     rec_we;
    logic                     rec_re;
    logic [RI-1:0]            rec_addr;

    always_comb begin
        map_we    = cmd.clear | (cmd.eval & ev_map_wr);
        map_waddr = cmd.clear ? clr_ptr_reg : wptr_reg;
        map_wdata = cmd.clear ? '0 : ev_map_wdata;
        map_re    = cmd.decode | (cmd.eval & ev_more);
        map_raddr = cmd.decode ? init_word : WI'(w_nxt);
        rec_we    = cmd.eval & ev_rec_wr;
        rec_re    = cmd.eval & ev_rec_rd;
        rec_addr  = RI'(ev_slot);
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (map_re) begin
            map_q_reg <= map_mem[map_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_addr] <= data_reg;
        end
        if (rec_re) begin
            rec_q_reg <= rec_mem[rec_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            siu_reg       <= SIU_RESET;
            page_reg      <= '0;
            count_reg     <= '0;
            clr_ptr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == CFG_SLOTS_IN_USE) begin
                siu_reg <= cfg_data[SIU_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_PAGE_NUMBER) begin
                page_reg <= cfg_data[PAGE_W-1:0];
            end
            if (cmd.clear) begin
                clr_ptr_reg <= clr_ptr_reg + WI'(1);
            end
            if (cmd.eval && ev_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.eval && ev_dec) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            cmd_reg  <= cmd_t'(in_command);
            slot_reg <= in_slot;
            data_reg <= in_record_data[RECORD_BITS-1:0];
        end
        if (cmd.decode) begin
            wptr_reg       <= init_word;
            res_status_reg <= dec_status;
            res_slot_reg   <= '0;
            res_data_reg   <= '0;
        end
        if (cmd.eval) begin
            if (ev_more) begin
                wptr_reg <= WI'(w_nxt);
            end
            res_status_reg <= ev_status;
            if (ev_set_slot) begin
                res_slot_reg <= ev_slot;
            end
        end
        if (cmd.capture) begin
            res_data_reg <= rec_q_reg;
        end
        if (cmd.load) begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= RSLOT_W'(res_slot_reg);
            out_page_reg   <= page_reg;
            out_data_reg   <= res_data_reg;
            out_used_reg   <= USED_W'(count_reg);
            out_full_reg   <= (LIMW'(count_reg) == lim);
            out_empty_reg  <= (count_reg == '0);
        end
    end

    always_comb begin
        sts.clear_last = (clr_ptr_reg == WI'(NWORDS - 1));
        sts.dec_done   = dec_done;
        sts.ev_more    = ev_more;
        sts.ev_rec     = ev_rec_rd;
        sts.out_free   = !out_valid_reg || m_tready;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tuser   = out_status_reg;
    assign m_tdata   = {{OUT_PAD_W{1'b0}}, out_empty_reg, out_full_reg, out_used_reg,
                        DATA_W'(out_data_reg), out_page_reg, out_slot_reg};

endmodule

`default_nettype wire

[sv/bitmap_slot_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// slotted-page record store with an occupancy bitmap and first-free search
// ----------------------------------------------------------------------------
// Each request carries one command (insert, delete, get, get next, update) and
// yields exactly one response. Occupancy is kept in a bitmap memory of 32-bit
// words and records in a separate memory of SLOTS words. Requests are handled
// one at a time: each is decoded, then, unless it fails a range check or
// carries an undefined command, evaluated against the bitmap; a get that finds
// a record and a get next that hits add a record read before the response is
// loaded. Insert and get next read one further bitmap word for every word they
// have to scan (32 slots per word). The scan rate is set by the single read
// port of the bitmap memory. After reset the block runs a clearing pass over
// the bitmap, one word per cycle (ceil(SLOTS/32) words, 8 for the default
// build), and accepts no request until it is done; configuration writes are
// taken at any time but must only be issued while the block is idle. A finished
// response sits in an output register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator
    import bsa_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,        // built slot count
    parameter int RECORD_BITS = RECORD_BITS_DEF   // stored bits per record
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // request stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // slot[10:0], record_data[74:11], zero pad
    input  wire logic [CMD_W-1:0]       s_tuser,   // command[2:0]

    // response stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata,   // result_slot[7:0], result_page[23:8],
                                                   // result_data[87:24], used_slots[96:88],
                                                   // page_full[97], page_empty[98], zero pad
    output logic [STATUS_W-1:0]         m_tuser,   // status[2:0]

    // configuration writes: index 0 slots_in_use, index 1 page_number
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    ctrl_cmd_t ctrl_cmd;
    dp_sts_t   dp_sts;

    // sequencer: clear pass, then accept / decode / scan / record read / load
    bsa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (dp_sts),
        .cmd      (ctrl_cmd)
    );

    // bitmap and record memories, used count, config and output register
    bsa_datapath #(
        .SLOTS       (SLOTS),
        .RECORD_BITS (RECORD_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (ctrl_cmd),
        .sts            (dp_sts),
        .in_command     (s_tuser),
        .in_slot        (s_tdata[SLOT_W-1:0]),
        .in_record_data (s_tdata[SLOT_W +: DATA_W]),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bitmap slot allocator
// ----------------------------------------------------------------------------
// A scripted opening walks the corner cases with hand-typed status, slot and
// count. Randomized phases follow under several slot counts and page numbers.
// Each phase uses one of four idle patterns, and one phase holds the response
// side off for a long stretch. Every response is compared field by field with
// a shadow model of the bitmap, the record words and the used count.
// ----------------------------------------------------------------------------

module testbench;
    import bsa_pkg::*;

    localparam int      N_SLOTS       = SLOTS_DEF;
    localparam int      SETTLE_CYCLES = 16;          // quiet time before register writes and at the end
    localparam int      HOLD_CYCLES   = 400;         // long response back-pressure
    localparam longint  TIMEOUT_NS    = 5_000_000;
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5; // undefined command codes
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    // response tdata field offsets
    localparam int OFF_PAGE  = RSLOT_W;
    localparam int OFF_DATA  = OFF_PAGE + PAGE_W;
    localparam int OFF_USED  = OFF_DATA + DATA_W;
    localparam int OFF_FULL  = OFF_USED + USED_W;
    localparam int OFF_EMPTY = OFF_FULL + 1;

    typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

    typedef struct packed {
        status_t             status;
        logic [RSLOT_W-1:0]  rslot;
        logic [PAGE_W-1:0]   page;
        logic [DATA_W-1:0]   data;
        logic [USED_W-1:0]   used;
        logic                full;
        logic                empty;
    } resp_t;

    // one line of the scripted opening: a register write or a request
    typedef struct packed {
        logic                    is_write;
        logic [CFG_INDEX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0]   reg_value;
        logic [CMD_W-1:0]        cmd;
        logic signed [SLOT_W-1:0] slot;
        logic [DATA_W-1:0]       word;
        logic                    typed;      // status, slot and count typed in below
        status_t                 st;
        logic [RSLOT_W-1:0]      rslot;
        logic [USED_W-1:0]       used;
    } script_row_t;

    // clock and block ports
    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic                    s_tready;
    logic [IN_TDATA_W-1:0]   s_tdata   = '0;
    logic [CMD_W-1:0]        s_tuser   = '0;
    logic                    m_tvalid;
    logic                    m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]     m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data  = '0;

    // shadow of the page
    bit                  occ_map [N_SLOTS];
    logic [DATA_W-1:0]   rec_word [N_SLOTS];
    int                  occ_total = 0;
    logic [SIU_W-1:0]    siu_reg   = SIU_RESET;
    logic [PAGE_W-1:0]   page_reg  = '0;

    resp_t        awaited_responses [$];
    script_row_t  script [$];

    // idle control, read by the sender task and the response side
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    int fail_count        = 0;
    int requests_accepted = 0;
    int responses_checked = 0;
    int status_seen [5]   = '{0, 0, 0, 0, 0};

    // random phases: slot count, length, insert share and idle pattern
    localparam int N_PHASES = 9;
    localparam int PRESSURE_PHASE = 4;
    int        ph_limit  [N_PHASES] = '{5, 32, 256, 1, 33, 511, 0, 64, 200};
    int        ph_items  [N_PHASES] = '{75, 75, 80, 50, 75, 75, 35, 75, 80};
    int        ph_insert [N_PHASES] = '{50, 45, 40, 40, 45, 35, 30, 40, 65};
    gap_mode_t ph_gap    [N_PHASES] = '{GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH, GAP_NONE,
                                        GAP_BOTH, GAP_NONE, GAP_RECV, GAP_SEND};

    bitmap_slot_allocator u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // effective slot count: the register clipped to the built size
    function automatic int slot_limit();
        return (int'(siu_reg) > N_SLOTS) ? N_SLOTS : int'(siu_reg);
    endfunction

    // apply one command to the shadow page and return the response it must give
    function automatic resp_t apply_command(input logic [CMD_W-1:0] cmd,
                                            input logic signed [SLOT_W-1:0] slot,
                                            input logic [DATA_W-1:0] word);
        resp_t r;
        int    lim;
        int    s;
        int    i;
        bit    hit;
        r   = '0;
        lim = slot_limit();
        s   = int'(slot);
        hit = 1'b0;
        r.status = STS_OK;
        case (cmd) inside
            CMD_INSERT: begin
                r.status = STS_NO_FREE;
                for (i = 0; i < lim && !hit; i++) begin
                    if (!occ_map[i]) begin
                        occ_map[i]  = 1'b1;
                        rec_word[i] = word;
                        occ_total++;
                        r.status = STS_OK;
                        r.rslot  = i[RSLOT_W-1:0];
                        hit      = 1'b1;
                    end
                end
            end
            CMD_DELETE, CMD_GET, CMD_UPDATE: begin
                if (s < 0 || s >= lim) begin
                    r.status = STS_RANGE;
                end else if (!occ_map[s]) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.rslot = s[RSLOT_W-1:0];
                    if (cmd == CMD_DELETE) begin
                        occ_map[s] = 1'b0;
                        occ_total--;
                    end else if (cmd == CMD_GET) begin
                        r.data = rec_word[s];
                    end else begin
                        rec_word[s] = word;
                    end
                end
            end
            CMD_GET_NEXT: begin
                // scan starts one past the given slot, -1 means from the bottom
                r.status = STS_END;
                for (i = s + 1; i >= 0 && i < lim && !hit; i++) begin
                    if (occ_map[i]) begin
                        r.status = STS_OK;
                        r.rslot  = i[RSLOT_W-1:0];
                        r.data   = rec_word[i];
                        hit      = 1'b1;
                    end
                end
            end
            default: ;  // undefined codes leave the page alone
        endcase
        r.page  = page_reg;
        r.used  = USED_W'(occ_total);
        r.full  = (occ_total == lim);
        r.empty = (occ_total == 0);
        return r;
    endfunction

    // script building
    task automatic add_request(input logic [CMD_W-1:0] cmd, input int slot,
                               input logic [DATA_W-1:0] word);
        script_row_t row;
        row      = '0;
        row.cmd  = cmd;
        row.slot = slot[SLOT_W-1:0];
        row.word = word;
        script.push_back(row);
    endtask

    task automatic add_checked(input logic [CMD_W-1:0] cmd, input int slot,
                               input logic [DATA_W-1:0] word, input status_t st,
                               input int rslot, input int used);
        script_row_t row;
        row       = '0;
        row.cmd   = cmd;
        row.slot  = slot[SLOT_W-1:0];
        row.word  = word;
        row.typed = 1'b1;
        row.st    = st;
        row.rslot = rslot[RSLOT_W-1:0];
        row.used  = used[USED_W-1:0];
        script.push_back(row);
    endtask

    task automatic add_write(input logic [CFG_INDEX_W-1:0] idx, input int value);
        script_row_t row;
        row           = '0;
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = value[CFG_DATA_W-1:0];
        script.push_back(row);
    endtask

    // offer one request after a random gap and wait for it to be taken
    task automatic issue_request(input logic [CMD_W-1:0] cmd,
                                 input logic signed [SLOT_W-1:0] slot,
                                 input logic [DATA_W-1:0] word, output resp_t pred);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_TDATA_W - SLOT_W - DATA_W){1'b0}}, word, slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = apply_command(cmd, slot, word);
        requests_accepted++;
    endtask

    // register write, only once every response is back and the block is quiet
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_SLOTS_IN_USE) begin
            siu_reg = value[SIU_W-1:0];
        end else if (idx == CFG_PAGE_NUMBER) begin
            page_reg = value;
        end
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // response side: random stalls, or a counted hold-off when one is armed
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // response checker
    always @(posedge aclk) begin : response_check
        resp_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_responses.size() == 0) begin
                $error("response with no request pending: status %0d", m_tuser);
                fail_count++;
            end else begin
                want = awaited_responses.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("result_slot", want.rslot, m_tdata[0 +: RSLOT_W]);
                check_field("result_page", want.page, m_tdata[OFF_PAGE +: PAGE_W]);
                check_field("result_data", want.data, m_tdata[OFF_DATA +: DATA_W]);
                check_field("used_slots", want.used, m_tdata[OFF_USED +: USED_W]);
                check_field("page_full", want.full, m_tdata[OFF_FULL]);
                check_field("page_empty", want.empty, m_tdata[OFF_EMPTY]);
                responses_checked++;
                if (m_tuser < 5) status_seen[m_tuser]++;
            end
        end
    end

    initial begin : stimulus
        resp_t                   pred;
        script_row_t             row;
        logic [CMD_W-1:0]        cmd;
        logic signed [SLOT_W-1:0] slot;
        logic [DATA_W-1:0]       word;
        int                      occ_list [$];
        int                      ph;
        int                      n;
        int                      k;
        int                      p;
        int                      lim;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // opening script, empty page with reset settings first
        add_checked(CMD_GET,      0,    '0, STS_EMPTY, 0, 0);
        add_checked(CMD_GET_NEXT, -1,   '0, STS_END,   0, 0);
        add_checked(CMD_DELETE,   255,  '0, STS_EMPTY, 0, 0);
        add_checked(CMD_UPDATE,   256,  '1, STS_RANGE, 0, 0);
        add_checked(CMD_GET,      -1,   '0, STS_RANGE, 0, 0);
        add_checked(CMD_INSERT,   0,    '1, STS_OK, 0, 1);
        add_checked(CMD_INSERT,   1023, '0, STS_OK, 1, 2);
        add_checked(CMD_INSERT,   5,    64'h8000_0000_0000_0001, STS_OK, 2, 3);
        add_request(CMD_GET,      0,    '0);
        add_checked(CMD_GET_NEXT, -1,   '0, STS_OK,  0, 3);
        add_checked(CMD_GET_NEXT, 0,    '0, STS_OK,  1, 3);
        add_checked(CMD_GET_NEXT, 2,    '0, STS_END, 0, 3);
        add_checked(CMD_GET_NEXT, 255,  '0, STS_END, 0, 3);   // scan starts past the page
        add_checked(CMD_UPDATE,   1,    64'hA5A5_5A5A_C3C3_3C3C, STS_OK, 1, 3);
        add_request(CMD_GET,      1,    '0);
        add_checked(CMD_DELETE,   1,    '0, STS_OK,    1, 2);
        add_checked(CMD_GET,      1,    '0, STS_EMPTY, 0, 2);
        add_checked(CMD_INSERT,   0,    64'h0123_4567_89AB_CDEF, STS_OK, 1, 3); // refills hole
        add_checked(CMD_RSVD_FIRST, 1023, '1, STS_OK, 0, 3);  // undefined codes do nothing
        add_checked(CMD_RSVD_LAST,  1023, '1, STS_OK, 0, 3);
        // four slots, top page number: page fills up
        add_write(CFG_PAGE_NUMBER, 16'hFFFF);
        add_write(CFG_SLOTS_IN_USE, 4);
        add_checked(CMD_INSERT,   0,    '1, STS_OK,      3, 4);
        add_checked(CMD_INSERT,   0,    '1, STS_NO_FREE, 0, 4);
        // lowered limit hides marked slots but they stay counted
        add_write(CFG_SLOTS_IN_USE, 2);
        add_checked(CMD_GET,      3,    '0, STS_RANGE, 0, 4);
        add_checked(CMD_GET_NEXT, 1,    '0, STS_END,   0, 4);
        // zero slots: everything out of range
        add_write(CFG_SLOTS_IN_USE, 0);
        add_checked(CMD_GET,      0,    '0, STS_RANGE, 0, 4);
        // above the built size acts as the built size
        add_write(CFG_SLOTS_IN_USE, 511);
        add_checked(CMD_INSERT,   0,    '0, STS_OK, 4, 5);

        foreach (script[i]) begin
            row = script[i];
            if (row.is_write) begin
                write_register(row.reg_index, row.reg_value);
            end else begin
                issue_request(row.cmd, row.slot, row.word, pred);
                if (row.typed) begin
                    pred.status = row.st;
                    pred.rslot  = row.rslot;
                    pred.used   = row.used;
                end
                awaited_responses.push_back(pred);
            end
        end

        // randomized phases
        for (ph = 0; ph < N_PHASES; ph++) begin
            write_register(CFG_SLOTS_IN_USE, CFG_DATA_W'(ph_limit[ph]));
            write_register(CFG_PAGE_NUMBER, CFG_DATA_W'($urandom_range(16'hFFFF)));
            case (ph_gap[ph])
                GAP_SEND: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                GAP_RECV: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                GAP_BOTH: begin send_idle_pct = 23; recv_stall_pct = 23; end
                default:  begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            // long back-pressure while requests keep coming, so the block backs up
            if (ph == PRESSURE_PHASE) hold_left = HOLD_CYCLES;

            for (n = 0; n < ph_items[ph]; n++) begin
                lim = slot_limit();
                occ_list.delete();
                for (k = 0; k < lim; k++) begin
                    if (occ_map[k]) occ_list.push_back(k);
                end

                // command mix: inserts weighted per phase, a few undefined codes
                p = $urandom_range(99);
                if (p < ph_insert[ph]) begin
                    cmd = CMD_INSERT;
                end else if (p < 97) begin
                    case ($urandom_range(3))
                        0:       cmd = CMD_DELETE;
                        1:       cmd = CMD_GET;
                        2:       cmd = CMD_GET_NEXT;
                        default: cmd = CMD_UPDATE;
                    endcase
                end else begin
                    cmd = CMD_W'($urandom_range(CMD_RSVD_LAST, CMD_RSVD_FIRST));
                end

                // slot: mostly occupied ones, some free, a few out of range
                p = $urandom_range(99);
                if (p < 8) begin
                    case ($urandom_range(3))
                        0:       slot = SLOT_W'(-1);
                        1:       slot = SLOT_W'(lim);
                        2:       slot = SLOT_W'($urandom_range(1023, lim));
                        default: slot = SLOT_W'(1023);
                    endcase
                end else if (cmd == CMD_GET_NEXT && p < 25) begin
                    slot = SLOT_W'(-1);
                end else if (p < 75 && occ_list.size() > 0) begin
                    slot = SLOT_W'(occ_list[$urandom_range(occ_list.size() - 1)]);
                    if (cmd == CMD_GET_NEXT && $urandom_range(1)) slot = SLOT_W'(slot - 1);
                end else begin
                    slot = SLOT_W'((lim > 0) ? $urandom_range(lim - 1) : 0);
                end

                word = {$urandom, $urandom};
                issue_request(cmd, slot, word, pred);
                awaited_responses.push_back(pred);
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run: %0d requests accepted, %0d responses checked, %0d slot-count settings",
                 requests_accepted, responses_checked, N_PHASES + 4);
        $display("statuses: ok %0d, out of range %0d, empty %0d, no free %0d, end of page %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
